// ===== src/ucb_child_selector_core_macros.svh =====
// Assertion macros for the child selector core.
// Included by the top level only; depends on nothing else.
`ifndef UCB_CHILD_SELECTOR_CORE_MACROS_SVH
`define UCB_CHILD_SELECTOR_CORE_MACROS_SVH
// Checks that a condition implies a consequence on the same edge.
`define UCS_ASSERT_IMP(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("check failed");
// Checks that a condition implies a consequence on the next edge.
`define UCS_ASSERT_NXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("check failed");
`endif

// ===== src/ucs_pkg.sv =====
// Package of the child selector: payload types, register indexes, constants.
// Depends on nothing.
`default_nettype none
package ucs_pkg;
	localparam int unsigned ScoreW = 48;
	localparam logic [47:0] ScoreMax = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] Ln2Fx = 16'd45426;

	typedef enum logic [1:0] {
		CMD_VISITS = 2'd0,
		CMD_MEAN   = 2'd1,
		CMD_UCB    = 2'd2,
		CMD_PRIOR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_EXPL_GAIN  = 3'd0,
		REG_UNEXP_VAL  = 3'd1,
		REG_LOSS_WT    = 3'd2,
		REG_LOG_GAIN   = 3'd3,
		REG_SCALE_PAR  = 3'd4,
		REG_THR_MODE   = 3'd5,
		REG_MIN_VISITS = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [23:0] parent_visits;
		logic [23:0] child_visits;
		logic [39:0] child_value_sum;
		logic [16:0] child_mean;
		logic [16:0] child_prior;
		logic        child_present;
		logic        last_child;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  best_index;
		logic [47:0] best_score;
		logic        none_found;
	} out_item_t;

	typedef struct packed {
		logic [23:0] exploration_gain;
		logic [23:0] unexpanded_value;
		logic [16:0] loss_weight;
		logic [23:0] log_term_gain;
		logic        scale_by_parent;
		logic        threshold_mode;
		logic [23:0] min_visits;
	} cfg_t;

	// Classified transaction handed from the front to the back end.
	typedef struct packed {
		logic        score_it;   // child is scored
		logic        close_it;   // node closes after this transaction
		logic        expanded;
		in_item_t    item;
	} job_t;
endpackage
`default_nettype wire

// ===== src/ucb_child_selector_core.sv =====
// Child selector top level: one transaction per child. Non-UCB children are taken and
// then update the running best; UCB children are first scored by the shared bit-serial
// divider and square-root unit (two 64-step divides, two 32-step roots, 16 log squarings).
// A closing transaction adds a result state before the back end takes the next job.
// Reset (arst_n low) clears running best, positions, queue and restores registers.
`default_nettype none
`include "ucb_child_selector_core_macros.svh"
module ucb_child_selector_core #(
	parameter int unsigned MAX_KIDS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire ucs_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output ucs_pkg::out_item_t     out_data,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [23:0]       cfg_data
);
	import ucs_pkg::*;

	cfg_t cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{24'd65536, 24'd65536, 17'd65536, 24'd0, 1'b1, 1'b0, 24'd0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPL_GAIN:  cfg_q.exploration_gain <= cfg_data;
				REG_UNEXP_VAL:  cfg_q.unexpanded_value <= cfg_data;
				REG_LOSS_WT:    cfg_q.loss_weight <= cfg_data[16:0];
				REG_LOG_GAIN:   cfg_q.log_term_gain <= cfg_data;
				REG_SCALE_PAR:  cfg_q.scale_by_parent <= cfg_data[0];
				REG_THR_MODE:   cfg_q.threshold_mode <= cfg_data[0];
				REG_MIN_VISITS: cfg_q.min_visits <= cfg_data;
				default: ;
			endcase
		end
	end

	// Two-entry queue between the front and back end.
	job_t job_f, q_mem [2];
	logic [1:0] q_cnt_q;
	logic q_wr_q, q_rd_q;
	logic take_in, job_take;

	assign in_stall = (q_cnt_q == 2'd2);
	assign take_in = in_valid && !in_stall;

	ucs_front #(.MAX_KIDS(MAX_KIDS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .item(in_data),
		.take(take_in), .job(job_f)
	);

	always_ff @(posedge clk) if (take_in) q_mem[q_wr_q] <= job_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0; q_wr_q <= 1'b0; q_rd_q <= 1'b0;
		end else begin
			if (take_in) q_wr_q <= ~q_wr_q;
			if (job_take) q_rd_q <= ~q_rd_q;
			q_cnt_q <= q_cnt_q + 2'(take_in) - 2'(job_take);
		end
	end

	ucs_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .job(q_mem[q_rd_q]),
		.job_valid(q_cnt_q != 2'd0), .job_take(job_take),
		.res_valid(out_valid), .res_stall(out_stall), .res(out_data)
	);

	`UCS_ASSERT_IMP(a_no_overflow, clk, arst_n, q_cnt_q == 2'd2, !take_in)
	`UCS_ASSERT_IMP(a_none_zero, clk, arst_n, out_valid && out_data.none_found,
		out_data.best_score == 48'd0)
	`UCS_ASSERT_NXT(a_out_drains, clk, arst_n, out_valid && !out_stall, !out_valid)
endmodule
`default_nettype wire

// ===== src/ucs_front.sv =====
// Front end: accepts input transactions, counts positions and classifies them.
// Depends on ucs_pkg.
`default_nettype none
module ucs_front #(
	parameter int unsigned MAX_KIDS = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ucs_pkg::cfg_t  cfg,
	input  wire ucs_pkg::in_item_t item,
	input  wire logic           take,
	output ucs_pkg::job_t       job
);
	import ucs_pkg::*;
	localparam int unsigned PosW = $clog2(MAX_KIDS + 1);
	logic [PosW-1:0] pos_q;
	logic            fits;

	assign fits = ({1'b0, pos_q} < (PosW+1)'(MAX_KIDS));

	always_comb begin
		job.item = item;
		job.score_it = item.child_present && fits;
		job.close_it = !item.child_present || item.last_child;
		job.expanded = cfg.threshold_mode ? (item.child_visits > cfg.min_visits)
			: (item.child_visits != 24'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			if (job.close_it) pos_q <= '0;
			else if (job.score_it) pos_q <= pos_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== src/ucs_back.sv =====
// Back end: scores one job at a time, UCB jobs with a shared iterative unit, and
// keeps the running best. Depends on ucs_pkg.
`default_nettype none
module ucs_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ucs_pkg::cfg_t  cfg,
	input  wire ucs_pkg::job_t  job,
	input  wire logic           job_valid,
	output logic                job_take,
	output logic                res_valid,
	input  wire logic           res_stall,
	output ucs_pkg::out_item_t  res
);
	import ucs_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SQA   = 11'b000_0000_0010,  // sqrt of parent visits
		ST_CMUL  = 11'b000_0000_0100,
		ST_LOG   = 11'b000_0000_1000,  // log2 by squaring
		ST_LNMUL = 11'b000_0001_0000,
		ST_DIV   = 11'b000_0010_0000,  // shared divider
		ST_DIV2  = 11'b000_0100_0000,
		ST_SQB   = 11'b000_1000_0000,
		ST_SUM   = 11'b001_0000_0000,
		ST_UPD   = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} st_t;

	st_t st_q;
	job_t job_q;
	logic [7:0] pos_q, best_idx_q;
	logic [47:0] best_q, score_q;
	logic have_q;
	logic [6:0] cnt_q;

	// shared sqrt / divide registers
	logic [63:0] rad_q, res_q, bit_q;
	logic [63:0] num_q;
	logic [47:0] den_q;
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] y_q;
	logic [4:0]  n_q;
	logic [20:0] lg_q;
	logic [47:0] c_q, lnv_q, explore_q, logt_q;
	logic [47:0] div_q;

	logic [63:0] sq_t;
	logic [61:0] ysq;
	logic [64:0] rem_sh;
	logic        div_ge;
	logic [47:0] lw;
	logic [41:0] vis_fx, losses;
	logic [49:0] total;
	logic [4:0]  msb;
	logic [47:0] ucb_score, cand_score;

	assign lw = (cfg.loss_weight > 17'd65536) ? 48'd65536 : 48'(cfg.loss_weight);
	assign vis_fx = {2'b0, job_q.item.child_visits, 16'd0};
	assign losses = (vis_fx > {2'b0, job_q.item.child_value_sum})
		? vis_fx - {2'b0, job_q.item.child_value_sum} : 42'd0;
	assign sq_t = res_q + bit_q;
	// The normalized log operand stays below 2^31, so 31 bits are squared.
	assign ysq = y_q[30:0] * y_q[30:0];
	assign rem_sh = {rem_q, num_q[63]};
	assign div_ge = (rem_sh >= {17'd0, den_q});
	assign total = 50'(job_q.expanded ? 48'(job_q.item.child_mean)
		: 48'(cfg.unexpanded_value)) + 50'(explore_q) + 50'(logt_q);

	// Score used by the update step.
	assign ucb_score = (total > 50'(ScoreMax)) ? ScoreMax : total[47:0];
	assign cand_score = (job_q.item.cmd == CMD_UCB) ? ucb_score : score_q;

	// Position of the leading one of the parent visit count.
	always_comb begin
		msb = '0;
		for (int i = 1; i < 24; i++)
			if (job_q.item.parent_visits[i]) msb = 5'(i);
	end

	assign job_take = (st_q == ST_IDLE) && job_valid;
	assign res_valid = (st_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			have_q <= 1'b0;
			best_q <= '0;
			best_idx_q <= '0;
			pos_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (job_valid) begin
					job_q <= job;
					if (!job.score_it) st_q <= job.close_it ? ST_UPD : ST_IDLE;
					else if (job.item.cmd != CMD_UCB) begin
						case (job.item.cmd)
							CMD_VISITS: score_q <= {8'd0, job.item.child_visits, 16'd0};
							CMD_MEAN: score_q <= 48'(job.item.child_mean);
							default: score_q <= 48'(job.item.child_prior);
						endcase
						st_q <= ST_UPD;
					end else begin
						rad_q <= {8'd0, job.item.parent_visits, 32'd0};
						res_q <= '0;
						bit_q <= 64'd1 << 62;
						cnt_q <= 7'd31;
						st_q <= ST_SQA;
					end
				end
				ST_SQA: begin
					if (rad_q >= sq_t) begin
						rad_q <= rad_q - sq_t;
						res_q <= (res_q >> 1) + bit_q;
					end else res_q <= res_q >> 1;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 7'd0) st_q <= ST_CMUL;
				end
				ST_CMUL: begin
					// The root of a 56-bit radicand fits in 28 bits.
					c_q <= cfg.scale_by_parent ? 48'((52'(cfg.exploration_gain)
						* 52'(res_q[27:0])) >> 16) : 48'(cfg.exploration_gain);
					div_q <= 48'((64'(losses) * 64'(lw)
						+ 64'(vis_fx) * (64'd65536 - 64'(lw))) >> 16);
					n_q <= msb;
					cnt_q <= 7'd16;
					lg_q <= '0;
					st_q <= ST_LOG;
				end
				ST_LOG: begin
					if (cnt_q == 7'd16) begin
						y_q <= 64'(job_q.item.parent_visits) << (30 - n_q);
						cnt_q <= cnt_q - 1'b1;
					end else begin
						if (ysq[61]) begin
							y_q <= 64'(ysq[61:31]);
							lg_q <= {lg_q[19:0], 1'b1};
						end else begin
							y_q <= 64'(ysq[60:30]);
							lg_q <= {lg_q[19:0], 1'b0};
						end
						if (cnt_q == 7'd0) st_q <= ST_LNMUL;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_LNMUL: begin
					lnv_q <= (job_q.item.parent_visits == 24'd0) ? 48'd0
						: 48'((({27'd0, n_q, lg_q[15:0]}) * 48'(Ln2Fx)) >> 16);
					num_q <= 64'(c_q) * 64'(job_q.item.child_prior);
					den_q <= 48'd65536 + div_q;
					rem_q <= '0;
					cnt_q <= 7'd63;
					st_q <= ST_DIV;
				end
				ST_DIV, ST_DIV2: begin
					if (cnt_q != 7'd0) begin
						if (div_ge) begin
							rem_q <= 64'(rem_sh - {17'd0, den_q});
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= rem_sh[63:0];
							quo_q <= {quo_q[62:0], 1'b0};
						end
						num_q <= num_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end else if (st_q == ST_DIV) begin
						explore_q <= 48'({quo_q[62:0], div_ge});
						num_q <= {lnv_q, 16'd0};
						den_q <= 48'd1 + 48'(job_q.item.child_visits);
						rem_q <= '0;
						cnt_q <= 7'd63;
						st_q <= ST_DIV2;
					end else begin
						rad_q <= {quo_q[62:0], div_ge};
						res_q <= '0;
						bit_q <= 64'd1 << 62;
						cnt_q <= 7'd31;
						st_q <= ST_SQB;
					end
				end
				ST_SQB: begin
					if (rad_q >= sq_t) begin
						rad_q <= rad_q - sq_t;
						res_q <= (res_q >> 1) + bit_q;
					end else res_q <= res_q >> 1;
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 7'd0) st_q <= ST_SUM;
				end
				ST_SUM: begin
					logt_q <= 48'((52'(cfg.log_term_gain) * 52'(res_q[27:0])) >> 16);
					st_q <= ST_UPD;
				end
				ST_UPD: begin
					if (job_q.score_it) begin
						if (!have_q || cand_score > best_q) begin
							best_q <= cand_score;
							best_idx_q <= pos_q;
							have_q <= 1'b1;
						end
						pos_q <= pos_q + 1'b1;
					end
					st_q <= job_q.close_it ? ST_OUT : ST_IDLE;
				end
				ST_OUT: if (!res_stall) begin
					have_q <= 1'b0;
					best_q <= '0;
					best_idx_q <= '0;
					pos_q <= '0;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		res.best_index = have_q ? best_idx_q : 8'd0;
		res.best_score = have_q ? best_q : 48'd0;
		res.none_found = !have_q;
	end
endmodule
`default_nettype wire

// ===== tb/sv/ucs_selection_checker.sv =====
// Scoreboard for the child selector: predicts each closed node's winner and compares.
// Depends on ucs_pkg for the payload, register and command types.
`timescale 1ns / 1ps
module ucs_selection_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire ucs_pkg::in_item_t in_data,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire ucs_pkg::out_item_t out_data,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [23:0]       cfg_data,
	output int                     mismatches,
	output int                     pending,
	output int                     nodes_checked,
	output int                     empty_nodes
);
	import ucs_pkg::*;

	localparam int MaxKids = 256;

	cfg_t            regs;
	logic [47:0]     best_score;
	logic [7:0]      best_index;
	logic            have_best;
	int              position;
	out_item_t       winners_due[$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] log2_fixed(input logic [31:0] x);
		int          n;
		logic [63:0] y;
		logic [63:0] frac;
		n = 0;
		frac = 0;
		while ((x >> (n + 1)) != 0)
			n++;
		y = {32'b0, x} << (30 - n);
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			frac = frac << 1;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				frac = frac | 1;
			end
		end
		return (64'(n) << 16) | frac;
	endfunction

	function automatic logic [47:0] puct_score(input in_item_t it);
		logic        expanded;
		logic [63:0] base, gain, vis_fx, losses, lw, divisor, explore, lnv, logterm, total;
		expanded = regs.threshold_mode ? (it.child_visits > regs.min_visits)
			: (it.child_visits != 0);
		base = expanded ? 64'(it.child_mean) : 64'(regs.unexpanded_value);
		gain = 64'(regs.exploration_gain);
		vis_fx = 64'(it.child_visits) << 16;
		losses = (vis_fx > 64'(it.child_value_sum)) ? vis_fx - 64'(it.child_value_sum) : 0;
		lw = (regs.loss_weight > 17'd65536) ? 64'd65536 : 64'(regs.loss_weight);
		lnv = 0;
		if (regs.scale_by_parent)
			gain = (gain * int_sqrt(64'(it.parent_visits) << 32)) >> 16;
		divisor = (losses * lw + vis_fx * (64'd65536 - lw)) >> 16;
		explore = (gain * 64'(it.child_prior)) / (64'd65536 + divisor);
		if (it.parent_visits != 0)
			lnv = (log2_fixed(32'(it.parent_visits)) * 64'(Ln2Fx)) >> 16;
		logterm = (64'(regs.log_term_gain)
			* int_sqrt((lnv << 16) / (64'd1 + 64'(it.child_visits)))) >> 16;
		total = base + explore + logterm;
		return (total > 64'(ScoreMax)) ? ScoreMax : total[47:0];
	endfunction

	function automatic logic [47:0] child_score(input in_item_t it);
		case (cmd_t'(it.cmd))
			CMD_VISITS: return 48'(it.child_visits) << 16;
			CMD_MEAN:   return 48'(it.child_mean);
			CMD_UCB:    return puct_score(it);
			default:    return 48'(it.child_prior);
		endcase
	endfunction

	task automatic absorb_child(input in_item_t it);
		logic [47:0] s;
		out_item_t   w;
		if (it.child_present) begin
			if (position < MaxKids) begin
				s = child_score(it);
				if (!have_best || s > best_score) begin
					best_score = s;
					best_index = position[7:0];
					have_best = 1'b1;
				end
				position++;
			end
			if (!it.last_child)
				return;
		end
		w.best_index = have_best ? best_index : 8'd0;
		w.best_score = have_best ? best_score : 48'd0;
		w.none_found = !have_best;
		winners_due.insert(winners_due.size(), w);
		best_score = 0;
		best_index = 0;
		have_best = 0;
		position = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			regs.exploration_gain = 24'd65536;
			regs.unexpanded_value = 24'd65536;
			regs.loss_weight = 17'd65536;
			regs.log_term_gain = 24'd0;
			regs.scale_by_parent = 1'b1;
			regs.threshold_mode = 1'b0;
			regs.min_visits = 24'd0;
			best_score = 0;
			best_index = 0;
			have_best = 0;
			position = 0;
			winners_due.delete();
			mismatches = 0;
			nodes_checked = 0;
			empty_nodes = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_EXPL_GAIN:  regs.exploration_gain = cfg_data;
					REG_UNEXP_VAL:  regs.unexpanded_value = cfg_data;
					REG_LOSS_WT:    regs.loss_weight = cfg_data[16:0];
					REG_LOG_GAIN:   regs.log_term_gain = cfg_data;
					REG_SCALE_PAR:  regs.scale_by_parent = cfg_data[0];
					REG_THR_MODE:   regs.threshold_mode = cfg_data[0];
					REG_MIN_VISITS: regs.min_visits = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (winners_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result idx=%0d score=%h none=%b", $realtime,
							out_data.best_index, out_data.best_score, out_data.none_found);
				end else begin
					want = winners_due.pop_front();
					nodes_checked++;
					if (want.none_found)
						empty_nodes++;
					if (want !== out_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch exp idx=%0d score=%h none=%b, got idx=%0d score=%h none=%b",
								$realtime, want.best_index, want.best_score, want.none_found,
								out_data.best_index, out_data.best_score, out_data.none_found);
					end
				end
			end
			if (in_valid && !in_stall)
				absorb_child(in_data);
		end
		pending = winners_due.size();
	end
endmodule

// ===== tb/sv/tb.sv =====
// Top of the child selector testbench: clock, reset, stimulus and verdict.
// Depends on ucs_pkg, ucb_child_selector_core and ucs_selection_checker.
`timescale 1ns / 1ps
module tb;
	import ucs_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_we;
	logic [2:0] cfg_index;
	logic [23:0] cfg_data;

	int mismatches, pending, nodes_checked, empty_nodes;
	int children_sent;
	// Set by the stimulus to ask the receiver for a long hold-off; it clears it when done.
	bit long_hold;
	// When set, neither side inserts idle cycles any more.
	bit quiet;
	cfg_t cur;

	ucb_child_selector_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ucs_selection_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending),
		.nodes_checked(nodes_checked), .empty_nodes(empty_nodes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit; the slowest legal run is far below this.
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// Result side: random stall bursts, one long hold-off on request, none when quiet.
	initial begin
		out_stall <= 1'b0;
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 0;
				@(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				@(posedge clk);
			end
		end
	end

	function automatic in_item_t mk(cmd_t cmd, logic [23:0] pv, logic [23:0] cv,
			logic [39:0] vs, logic [16:0] mean, logic [16:0] prior, bit pres, bit last);
		in_item_t it;
		it.cmd = cmd;
		it.parent_visits = pv;
		it.child_visits = cv;
		it.child_value_sum = vs;
		it.child_mean = mean;
		it.child_prior = prior;
		it.child_present = pres;
		it.last_child = last;
		return it;
	endfunction

	// Holds valid until the transaction is taken. Valid stays high into the next
	// send unless a random gap is inserted.
	task automatic send(input in_item_t it);
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (in_stall);
		children_sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Sender pauses until every pending winner has been seen, then lets any
	// child still being scored in an open node finish.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_regs(input cfg_t c);
		cur = c;
		cfg_we <= 1'b1;
		cfg_index <= REG_EXPL_GAIN;  cfg_data <= c.exploration_gain;  @(posedge clk);
		cfg_index <= REG_UNEXP_VAL;  cfg_data <= c.unexpanded_value;  @(posedge clk);
		cfg_index <= REG_LOSS_WT;    cfg_data <= 24'(c.loss_weight);  @(posedge clk);
		cfg_index <= REG_LOG_GAIN;   cfg_data <= c.log_term_gain;     @(posedge clk);
		cfg_index <= REG_SCALE_PAR;  cfg_data <= 24'(c.scale_by_parent); @(posedge clk);
		cfg_index <= REG_THR_MODE;   cfg_data <= 24'(c.threshold_mode);  @(posedge clk);
		cfg_index <= REG_MIN_VISITS; cfg_data <= c.min_visits;        @(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.exploration_gain = 24'($urandom_range(0, 24'h3FFFF));
		c.unexpanded_value = 24'($urandom_range(0, 24'h1FFFF));
		c.loss_weight = 17'($urandom_range(0, 65536));
		c.log_term_gain = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'($urandom_range(0, 24'hFFFFFF));
		c.scale_by_parent = 1'($urandom_range(0, 1));
		c.threshold_mode = 1'($urandom_range(0, 1));
		c.min_visits = 24'($urandom_range(0, 20));
		return c;
	endfunction

	// Random child content. Visit counts cluster around zero and the threshold
	// so that both the expanded and unexpanded paths are taken.
	function automatic in_item_t random_child(cmd_t cmd, bit last);
		logic [23:0] pv, cv;
		logic [39:0] vs;
		case ($urandom_range(0, 3))
			0: cv = 0;
			1: cv = 24'($urandom_range(0, 8));
			2: cv = cur.min_visits + 24'($urandom_range(0, 2)) - 24'd1;
			default: cv = 24'($urandom_range(0, 24'hFFFFFF));
		endcase
		case ($urandom_range(0, 9))
			0: pv = 0;
			1, 2: pv = 24'($urandom_range(1, 64));
			default: pv = 24'($urandom_range(1, 24'hFFFFFF));
		endcase
		if ($urandom_range(0, 1) == 0)
			vs = {8'($urandom_range(0, 255)), $urandom()};
		else
			vs = ({16'b0, cv} << 16)
				- 40'(40'($urandom_range(0, 32'hFFFF_FFFF)) % ((40'(cv) << 16) + 40'd1));
		return mk(cmd, pv, cv, vs, 17'($urandom_range(0, 65536)),
			17'($urandom_range(0, 65536)), 1'b1, last);
	endfunction

	function automatic cmd_t random_cmd();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return CMD_UCB;
		return cmd_t'(r % 4);
	endfunction

	// One node: a few children, sometimes all of one kind, sometimes closed by an
	// empty transaction, sometimes only an empty transaction.
	task automatic random_node(input bit fast);
		int   kids;
		bit   mixed;
		cmd_t kind;
		kids = $urandom_range(1, 6);
		mixed = $urandom_range(0, 2) == 0;
		kind = fast ? cmd_t'($urandom_range(0, 1) ? CMD_VISITS : CMD_PRIOR) : random_cmd();
		if ($urandom_range(0, 11) == 0) begin
			send(mk(kind, 1, 0, 0, 0, 0, 1'b0, 1'($urandom_range(0, 1))));
			return;
		end
		for (int k = 0; k < kids; k++) begin
			if (mixed && !fast)
				kind = random_cmd();
			if (k == kids - 1 && $urandom_range(0, 7) == 0) begin
				send(random_child(kind, 1'b0));
				send(mk(kind, 1, 0, 0, 0, 0, 1'b0, 1'($urandom_range(0, 1))));
			end else begin
				send(random_child(kind, k == kids - 1));
			end
		end
	endtask

	initial begin
		cfg_t phases[8];
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		children_sent = 0;
		long_hold = 0;
		quiet = 0;
		arst_n = 1'b0;
		cur = random_cfg();
		cur.exploration_gain = 24'd65536;
		cur.unexpanded_value = 24'd65536;
		cur.loss_weight = 17'd65536;
		cur.log_term_gain = 0;
		cur.scale_by_parent = 1;
		cur.threshold_mode = 0;
		cur.min_visits = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under reset register values.
		send(mk(CMD_VISITS, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 1, 1));
		send(mk(CMD_MEAN, 1, 0, 0, 17'd0, 0, 1, 0));
		send(mk(CMD_MEAN, 1, 0, 0, 17'd65536, 0, 1, 0));
		// Equal scores keep the earlier child.
		send(mk(CMD_MEAN, 1, 0, 0, 17'd65536, 0, 1, 1));
		send(mk(CMD_PRIOR, 5, 3, 0, 0, 17'd65536, 1, 0));
		send(mk(CMD_PRIOR, 5, 3, 0, 0, 17'd0, 1, 1));
		// Unexpanded child, zero parent visits, value sum above visits.
		send(mk(CMD_UCB, 0, 0, 0, 17'd1000, 17'd65536, 1, 0));
		send(mk(CMD_UCB, 10, 4, 40'hFF_FFFF_FFFF, 17'd30000, 17'd20000, 1, 0));
		send(mk(CMD_UCB, 24'hFFFFFF, 24'hFFFFFF, 0, 17'd65536, 17'd65536, 1, 1));
		// A lone empty transaction reports that nothing was found.
		send(mk(CMD_VISITS, 1, 0, 0, 0, 0, 0, 1));
		send(mk(CMD_VISITS, 1, 0, 0, 0, 0, 0, 0));
		// An empty transaction closes an open node even without the last flag.
		send(mk(CMD_VISITS, 7, 2, 0, 0, 0, 1, 0));
		send(mk(CMD_UCB, 7, 9, 40'd589824, 17'd40000, 17'd100, 1, 0));
		send(mk(CMD_VISITS, 1, 0, 0, 0, 0, 0, 0));
		// Mixed score kinds inside one node.
		send(mk(CMD_PRIOR, 3, 1, 0, 0, 17'd500, 1, 0));
		send(mk(CMD_MEAN, 3, 1, 0, 17'd600, 0, 1, 0));
		send(mk(CMD_UCB, 3, 1, 40'd65536, 17'd100, 17'd65535, 1, 1));
		drain();

		phases[0] = '{24'hFFFFFF, 24'd0, 17'd0, 24'h010000, 1'b1, 1'b1, 24'd3};
		phases[1] = '{24'd0, 24'hFFFFFF, 17'h1FFFF, 24'hFFFFFF, 1'b0, 1'b0, 24'hFFFFFF};
		phases[2] = '{24'h010000, 24'h008000, 17'h08000, 24'h004000, 1'b1, 1'b1, 24'd0};
		for (int p = 3; p < 8; p++)
			phases[p] = random_cfg();

		for (int p = 0; p < 8; p++) begin
			write_regs(phases[p]);
			if (p == 7)
				quiet = 1;
			for (int n = 0; n < 24; n++)
				random_node(1'b0);
			if (p == 2) begin
				// Receiver holds off while short nodes pile up behind it.
				long_hold = 1;
				for (int n = 0; n < 40; n++)
					random_node(1'b1);
			end
			if (p == 4) begin
				// A node with more children than the block scores.
				for (int k = 0; k < 262; k++)
					send(random_child($urandom_range(0, 1) ? CMD_VISITS : CMD_MEAN, k == 261));
			end
			drain();
		end

		while (long_hold)
			@(posedge clk);
		drain();
		$display("Sent %0d child transactions under %0d register settings.", children_sent, 9);
		$display("Checked %0d node winners, %0d of them empty nodes.", nodes_checked, empty_nodes);
		if (mismatches == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
